/* hdl/pgmac_pkg.sv */
// Package: shared types and constants for the pellet grill mode and auger controller.
`timescale 1ns / 1ps
package pgmac_pkg;
	localparam int InitialTarget = 1100;
	localparam int MinTarget = 500;
	localparam int MaxTarget = 2800;
	localparam int TargetStep = 50;
	localparam int MaxDrive = 1000;

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_STARTUP = 3'd1;
	localparam logic [2:0] MODE_RUNNING = 3'd2;
	localparam logic [2:0] MODE_SHUTDOWN = 3'd3;
	localparam logic [2:0] MODE_ERROR = 3'd4;

	localparam logic [1:0] CAUSE_NONE = 2'd0;
	localparam logic [1:0] CAUSE_SENSOR = 2'd1;
	localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

	localparam logic [2:0] FUNC_TICK = 3'd0;
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_STOP = 3'd2;
	localparam logic [2:0] FUNC_RAISE = 3'd3;
	localparam logic [2:0] FUNC_LOWER = 3'd4;

	localparam logic [2:0] REG_VALID_LOW = 3'd0;
	localparam logic [2:0] REG_VALID_HIGH = 3'd1;
	localparam logic [2:0] REG_MARGIN = 3'd2;
	localparam logic [2:0] REG_TIMEOUT = 3'd3;
	localparam logic [2:0] REG_SHUT_FAN = 3'd4;
	localparam logic [2:0] REG_GAIN = 3'd5;
	localparam logic [2:0] REG_CYCLE = 3'd6;
	localparam logic [2:0] REG_MIN_DRIVE = 3'd7;
endpackage

/* hdl/pgmac_serial.sv */
// Shared serial unit: 32-bit remainder and shift-add multiply for the auger window.
`timescale 1ns / 1ps
module pgmac_serial (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] now_ms,
	input  logic [19:0] cycle_ms,
	input  logic [9:0]  drive,
	output logic        done,
	output logic        on
);
	import pgmac_pkg::*;

	typedef enum logic [3:0] {
		SU_IDLE = 4'b0001,
		SU_MOD  = 4'b0010,
		SU_MUL  = 4'b0100,
		SU_CMP  = 4'b1000
	} su_state_t;

	su_state_t   state_q;
	logic [5:0]  cnt_q;
	logic [31:0] num_q;
	logic [19:0] rem_q;
	logic [29:0] acc_q;
	logic [9:0]  drv_q;
	logic [19:0] cyc_q;
	logic [20:0] rem_sh;
	logic [20:0] rem_sub;

	// Restoring division step, one quotient bit per cycle
	assign rem_sh  = {rem_q, num_q[31]};
	assign rem_sub = rem_sh - {1'b0, cyc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				SU_IDLE: if (start) begin
					state_q <= SU_MOD;
					cnt_q   <= 6'd32;
				end
				SU_MOD: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= SU_MUL;
						cnt_q   <= 6'd10;
					end
				end
				SU_MUL: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= SU_CMP;
				end
				SU_CMP: begin
					state_q <= SU_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= SU_IDLE;
			endcase
		end
	end

	// Datapath: remainder, then cycle*drive accumulated one drive bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == SU_IDLE && start) begin
			num_q <= now_ms;
			rem_q <= '0;
			acc_q <= '0;
			drv_q <= drive;
			cyc_q <= cycle_ms;
		end else if (state_q == SU_MOD) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= rem_sub[20] ? rem_sh[19:0] : rem_sub[19:0];
		end else if (state_q == SU_MUL) begin
			acc_q <= {acc_q[28:0], 1'b0} + (drv_q[9] ? {10'd0, cyc_q} : 30'd0);
			drv_q <= {drv_q[8:0], 1'b0};
		end else if (state_q == SU_CMP) begin
			// pos < floor(P/1000)  <=>  pos*1000 < P - (P mod 1000) <=> pos*1000+999 < P
			on <= (cyc_q != '0) &&
				(({10'd0, rem_q} * 30'd1000 + 30'd999) < acc_q);
		end
	end
endmodule

/* hdl/pellet_grill_mode_and_auger_control_unit.sv */
// Top level: mode sequencer, drive computation and stream ports.
`timescale 1ns / 1ps
// Takes one event a transfer and returns one status word per event. A target, start or
// stop event, or a tick that finds the mode neither startup nor running, is worked in the
// mode rules and then loads the output register; the next event can be taken after that.
// Other ticks go through the mode rules, the drive from the registered product, then the
// shared serial unit (a start, 32 remainder steps over now_ms, 10 multiply steps for
// cycle*drive, a compare and the done strobe) and the load of the output register. The
// block is not ready while an event is in work; a finished result waits in the output
// register while the next event can already be taken, and the next result is held back
// in its last step until the waiting one has left.
module pellet_grill_mode_and_auger_control_unit #(
	parameter int INITIAL_TARGET = pgmac_pkg::InitialTarget,
	parameter int MIN_TARGET = pgmac_pkg::MinTarget,
	parameter int MAX_TARGET = pgmac_pkg::MaxTarget,
	parameter int TARGET_STEP = pgmac_pkg::TargetStep,
	parameter int MAX_DRIVE = pgmac_pkg::MaxDrive
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // func[2:0], now_ms[34:3], pit_temp[50:35], sensor_ok[51]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // mode_now, auger_on, fan_on, igniter_on, drive_level,
	                                   // target_now, error_cause
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import pgmac_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MODE  = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_AUGER = 5'b01000,
		ST_OUT   = 5'b10000
	} st_t;

	st_t          state_q;
	// config
	logic signed [15:0] vlow_q, vhigh_q;
	logic [10:0] margin_q;
	logic [31:0] timeout_q, shutfan_q;
	logic [15:0] gain_q;
	logic [19:0] cycle_q;
	logic [9:0]  mindrv_q;
	// state
	logic [2:0]  mode_q;
	logic [31:0] mstart_q;
	logic [14:0] target_q;
	logic [9:0]  drive_q;
	logic        aug_q, fan_q, ign_q;
	logic [1:0]  cause_q;
	// latched input
	logic [2:0]  func_q;
	logic [31:0] now_q;
	logic signed [15:0] pit_q;
	logic        ok_q;
	logic signed [33:0] prod_q;
	logic [2:0]  mode_pre_q;
	// output
	logic        ovalid_q;
	logic [39:0] odata_q;
	logic        out_free;

	logic        su_start;
	logic        su_done;
	logic        su_on;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign out_free = !ovalid_q || m_axis_tready;

	pgmac_serial u_serial (
		.clk(clk), .arst_n(arst_n), .start(su_start), .now_ms(now_q),
		.cycle_ms(cycle_q), .drive(drive_q), .done(su_done), .on(su_on)
	);

	// Combinational rule evaluation for one event
	logic        bad;
	logic [2:0]  m0;
	logic [31:0] elapsed;
	logic signed [16:0] diff;
	logic signed [16:0] thresh;
	logic [15:0] tgt_up, tgt_dn;
	always_comb begin
		bad = !ok_q || (pit_q < vlow_q) || (pit_q > vhigh_q);
		m0 = (bad && mode_q != MODE_ERROR) ? MODE_ERROR : mode_q;
		elapsed = now_q - mstart_q;
		diff = $signed({2'b00, target_q}) - 17'(pit_q);
		thresh = $signed({2'b00, target_q}) - $signed({6'd0, margin_q});
		tgt_up = {1'b0, target_q} + 16'(TARGET_STEP);
		tgt_dn = {1'b0, target_q} - 16'(TARGET_STEP);
	end

	// Drive from the registered product; the least running drive follows the mode
	// the rules started from, so a startup that ends this tick gets none
	logic [25:0] dshift;
	logic [9:0]  dnew;
	always_comb begin
		dshift = prod_q[33:8];
		if (prod_q <= 0) dnew = '0;
		else begin
			dnew = (dshift > 26'(MAX_DRIVE)) ? 10'(MAX_DRIVE) : dshift[9:0];
			if (mode_pre_q == MODE_RUNNING && dshift < {16'd0, mindrv_q})
				dnew = (mindrv_q > 10'(MAX_DRIVE)) ? 10'(MAX_DRIVE) : mindrv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vlow_q   <= -16'sd200;
			vhigh_q  <= 16'sd4000;
			margin_q <= 11'd100;
			timeout_q <= 32'd1800000;
			shutfan_q <= 32'd600000;
			gain_q   <= 16'd512;
			cycle_q  <= 20'd20000;
			mindrv_q <= 10'd50;
			mode_q   <= MODE_IDLE;
			mstart_q <= '0;
			target_q <= 15'(INITIAL_TARGET);
			drive_q  <= '0;
			aug_q    <= 1'b0;
			fan_q    <= 1'b0;
			ign_q    <= 1'b0;
			cause_q  <= CAUSE_NONE;
			ovalid_q <= 1'b0;
			su_start <= 1'b0;
		end else begin
			su_start <= 1'b0;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_VALID_LOW:  vlow_q <= cfg_data[15:0];
					REG_VALID_HIGH: vhigh_q <= cfg_data[15:0];
					REG_MARGIN:     margin_q <= cfg_data[10:0];
					REG_TIMEOUT:    timeout_q <= cfg_data;
					REG_SHUT_FAN:   shutfan_q <= cfg_data;
					REG_GAIN:       gain_q <= cfg_data[15:0];
					REG_CYCLE:      cycle_q <= cfg_data[19:0];
					REG_MIN_DRIVE:  mindrv_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_q <= ST_MODE;
				ST_MODE: begin
					state_q <= ST_OUT;
					unique case (func_q)
						FUNC_TICK: begin
							if (m0 != mode_q) begin
								mstart_q <= now_q;
								cause_q <= CAUSE_SENSOR;
							end
							mode_q <= m0;
							unique case (m0)
								MODE_IDLE: begin
									drive_q <= '0; aug_q <= 1'b0; fan_q <= 1'b0; ign_q <= 1'b0;
								end
								MODE_STARTUP: begin
									fan_q <= 1'b1; ign_q <= 1'b1;
									state_q <= ST_MUL;
									if (17'(pit_q) >= thresh) begin
										mode_q <= MODE_RUNNING; mstart_q <= now_q;
										cause_q <= CAUSE_NONE;
									end else if (elapsed > timeout_q) begin
										mode_q <= MODE_ERROR; mstart_q <= now_q;
										cause_q <= CAUSE_TIMEOUT;
									end
								end
								MODE_RUNNING: begin
									fan_q <= 1'b1; ign_q <= 1'b0;
									state_q <= ST_MUL;
								end
								MODE_SHUTDOWN: begin
									drive_q <= '0; aug_q <= 1'b0; ign_q <= 1'b0;
									if (elapsed < shutfan_q) fan_q <= 1'b1;
									else begin
										fan_q <= 1'b0; mode_q <= MODE_IDLE;
										mstart_q <= now_q; cause_q <= CAUSE_NONE;
									end
								end
								default: begin
									drive_q <= '0; aug_q <= 1'b0; fan_q <= 1'b1; ign_q <= 1'b0;
								end
							endcase
						end
						FUNC_START: if (mode_q == MODE_IDLE || mode_q == MODE_SHUTDOWN) begin
							mode_q <= MODE_STARTUP; mstart_q <= now_q; cause_q <= CAUSE_NONE;
						end
						FUNC_STOP: if (mode_q != MODE_IDLE) begin
							mode_q <= MODE_SHUTDOWN; mstart_q <= now_q; cause_q <= CAUSE_NONE;
						end
						FUNC_RAISE: target_q <= (tgt_up > 16'(MAX_TARGET)) ?
							15'(MAX_TARGET) : tgt_up[14:0];
						FUNC_LOWER: target_q <= ($signed(tgt_dn) < $signed(16'(MIN_TARGET))) ?
							15'(MIN_TARGET) : tgt_dn[14:0];
						default: ;
					endcase
				end
				ST_MUL: begin
					// product and pre-rule mode were registered last cycle
					drive_q <= dnew;
					su_start <= 1'b1;
					state_q <= ST_AUGER;
				end
				ST_AUGER: if (su_done) begin
					if (mode_q == MODE_STARTUP || mode_q == MODE_RUNNING) aug_q <= su_on;
					state_q <= ST_OUT;
				end
				// wait here while an earlier status word is still unclaimed
				ST_OUT: if (out_free) begin
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: latched event, product and result word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
			func_q <= s_axis_tdata[2:0];
			now_q  <= s_axis_tdata[34:3];
			pit_q  <= s_axis_tdata[50:35];
			ok_q   <= s_axis_tdata[51];
		end
		if (state_q == ST_MODE) begin
			prod_q <= diff * $signed({1'b0, gain_q});
			mode_pre_q <= m0;
		end
		if (state_q == ST_OUT && out_free)
			odata_q <= {7'd0, cause_q, target_q, drive_q, ign_q, fan_q, aug_q, mode_q};
	end

`ifndef ASSERT_OFF
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted while busy");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> m_axis_tvalid)
		else $error("result lost");
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[2:0] == MODE_ERROR) == (m_axis_tdata[32:31] != CAUSE_NONE))
		else $error("cause mismatch");
`endif
endmodule

/* bench/pellet_grill_mode_and_auger_control_unit_tb.sv */
// Testbench: stream-driven check of the grill mode sequencer against an in-bench predictor.
`timescale 1ns / 1ps
module pellet_grill_mode_and_auger_control_unit_tb;
	import pgmac_pkg::*;

	typedef struct {
		logic [2:0]         func;
		logic [31:0]        now;
		logic signed [15:0] pit;
		logic               ok;
	} grill_event_t;

	typedef struct {
		logic [2:0]  mode;
		logic        auger;
		logic        fan;
		logic        igniter;
		logic [9:0]  drive;
		logic [14:0] target;
		logic [1:0]  cause;
	} grill_status_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;  // func, now_ms, pit_temp, sensor_ok
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // mode_now, auger_on, fan_on, igniter_on, drive_level,
	                            // target_now, error_cause
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	pellet_grill_mode_and_auger_control_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predicted register copies
	int          p_valid_low, p_valid_high;
	int unsigned p_margin, p_timeout, p_shut_fan, p_gain, p_cycle, p_min_drive;
	logic [2:0]  p_mode;
	logic [31:0] p_mode_since;
	int          p_target;
	int          p_drive;
	logic        p_auger, p_fan, p_igniter;
	logic [1:0]  p_cause;

	grill_event_t  event_queue[$];
	grill_status_t status_queue[$];
	grill_event_t  cur_event;
	bit            taken;
	bit            calm;
	int            send_gap, recv_gap;
	int            fail_count, status_count, tick_count, cfg_count;
	logic [31:0]   gen_now;

	function automatic void switch_mode(logic [2:0] m, logic [31:0] now, logic [1:0] c);
		p_mode = m;
		p_mode_since = now;
		p_cause = c;
	endfunction

	function automatic void raise_error(logic [31:0] now, logic [1:0] c);
		if (p_mode != MODE_ERROR)
			switch_mode(MODE_ERROR, now, c);
	endfunction

	function automatic void update_drive(int pit);
		longint prod, d;
		prod = (longint'(p_target) - longint'(pit)) * longint'(p_gain);
		if (prod <= 0) begin
			d = 0;
		end else begin
			d = prod >>> 8;
			if (p_mode == MODE_RUNNING && d < longint'(p_min_drive))
				d = p_min_drive;
		end
		if (d > MaxDrive)
			d = MaxDrive;
		p_drive = int'(d);
	endfunction

	// Apply one event to the predicted state and return the status word it yields
	function automatic grill_status_t grill_next_status(grill_event_t ev);
		grill_status_t st;
		int pit;
		longint unsigned on_time, pos;
		pit = ev.pit;
		case (ev.func)
			FUNC_TICK: begin
				if (!ev.ok || pit < p_valid_low || pit > p_valid_high)
					raise_error(ev.now, CAUSE_SENSOR);
				case (p_mode)
					MODE_IDLE: begin
						p_drive = 0;
						{p_auger, p_fan, p_igniter} = 3'b000;
					end
					MODE_STARTUP: begin
						update_drive(pit);
						p_fan = 1'b1;
						p_igniter = 1'b1;
						if (pit >= p_target - int'(p_margin))
							switch_mode(MODE_RUNNING, ev.now, CAUSE_NONE);
						else if (ev.now - p_mode_since > p_timeout)
							raise_error(ev.now, CAUSE_TIMEOUT);
					end
					MODE_RUNNING: begin
						update_drive(pit);
						p_fan = 1'b1;
						p_igniter = 1'b0;
					end
					MODE_SHUTDOWN: begin
						p_drive = 0;
						{p_auger, p_igniter} = 2'b00;
						if (ev.now - p_mode_since < p_shut_fan) begin
							p_fan = 1'b1;
						end else begin
							p_fan = 1'b0;
							switch_mode(MODE_IDLE, ev.now, CAUSE_NONE);
						end
					end
					default: begin
						p_drive = 0;
						{p_auger, p_fan, p_igniter} = 3'b010;
					end
				endcase
				// auger time-proportioning
				if (p_mode == MODE_STARTUP || p_mode == MODE_RUNNING) begin
					p_auger = 1'b0;
					if (p_cycle != 0) begin
						pos = ev.now % p_cycle;
						on_time = (longint'(p_cycle) * longint'(p_drive)) / 1000;
						p_auger = pos < on_time;
					end
				end
			end
			FUNC_START: begin
				if (p_mode == MODE_IDLE || p_mode == MODE_SHUTDOWN)
					switch_mode(MODE_STARTUP, ev.now, CAUSE_NONE);
			end
			FUNC_STOP: begin
				if (p_mode != MODE_IDLE)
					switch_mode(MODE_SHUTDOWN, ev.now, CAUSE_NONE);
			end
			FUNC_RAISE: begin
				p_target = p_target + TargetStep;
				if (p_target > MaxTarget)
					p_target = MaxTarget;
			end
			FUNC_LOWER: begin
				p_target = p_target - TargetStep;
				if (p_target < MinTarget)
					p_target = MinTarget;
			end
			default: ;
		endcase
		st.mode = p_mode;
		st.auger = p_auger;
		st.fan = p_fan;
		st.igniter = p_igniter;
		st.drive = p_drive[9:0];
		st.target = p_target[14:0];
		st.cause = p_cause;
		return st;
	endfunction

	function automatic void set_register(logic [2:0] idx, logic [31:0] v);
		case (idx)
			REG_VALID_LOW:  p_valid_low = int'($signed(v[15:0]));
			REG_VALID_HIGH: p_valid_high = int'($signed(v[15:0]));
			REG_MARGIN:     p_margin = v[10:0];
			REG_TIMEOUT:    p_timeout = v;
			REG_SHUT_FAN:   p_shut_fan = v;
			REG_GAIN:       p_gain = v[15:0];
			REG_CYCLE:      p_cycle = v[19:0];
			REG_MIN_DRIVE:  p_min_drive = v[9:0];
			default: ;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Source side: present queued events, with random idle bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || taken) begin
				if (send_gap > 0) begin
					send_gap = send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (event_queue.size() > 0) begin
					cur_event = event_queue.pop_front();
					s_axis_tdata <= {4'b0, cur_event.ok, cur_event.pit, cur_event.now,
					                 cur_event.func};
					s_axis_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 17);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			taken = 1'b0;
		end
	end

	// Predict on each accepted event transfer
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			status_queue.push_back(grill_next_status(cur_event));
			if (cur_event.func == FUNC_TICK)
				tick_count++;
			taken = 1'b1;
		end
	end

	// Sink side: random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap = recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 16);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		grill_status_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (status_queue.size() == 0) begin
				$error("unexpected status word %h", m_axis_tdata);
				fail_count++;
			end else begin
				e = status_queue.pop_front();
				status_count++;
				if (m_axis_tdata[2:0] !== e.mode) begin
					$error("mode_now: expected %0d, got %0d", e.mode, m_axis_tdata[2:0]);
					fail_count++;
				end
				if (m_axis_tdata[3] !== e.auger) begin
					$error("auger_on: expected %0d, got %0d", e.auger, m_axis_tdata[3]);
					fail_count++;
				end
				if (m_axis_tdata[4] !== e.fan) begin
					$error("fan_on: expected %0d, got %0d", e.fan, m_axis_tdata[4]);
					fail_count++;
				end
				if (m_axis_tdata[5] !== e.igniter) begin
					$error("igniter_on: expected %0d, got %0d", e.igniter, m_axis_tdata[5]);
					fail_count++;
				end
				if (m_axis_tdata[15:6] !== e.drive) begin
					$error("drive_level: expected %0d, got %0d", e.drive, m_axis_tdata[15:6]);
					fail_count++;
				end
				if (m_axis_tdata[30:16] !== e.target) begin
					$error("target_now: expected %0d, got %0d", e.target, m_axis_tdata[30:16]);
					fail_count++;
				end
				if (m_axis_tdata[32:31] !== e.cause) begin
					$error("error_cause: expected %0d, got %0d", e.cause, m_axis_tdata[32:31]);
					fail_count++;
				end
			end
		end
	end

	task automatic add_event(logic [2:0] f, logic [31:0] now, int pit, logic ok);
		grill_event_t ev;
		ev.func = f;
		ev.now = now;
		ev.pit = 16'(pit);
		ev.ok = ok;
		event_queue.push_back(ev);
	endtask

	// Hold the source until every prediction has been matched, then let the block settle
	task automatic drain;
		do
			@(posedge clk);
		while (event_queue.size() != 0 || s_axis_tvalid || status_queue.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [31:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do
			@(posedge clk);
		while (!cfg_ready);
		set_register(idx, v);
		cfg_count++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_settings(int lo, int hi, int unsigned margin, int unsigned tmo,
	                             int unsigned shut, int unsigned gain, int unsigned cyc,
	                             int unsigned mind);
		write_register(REG_VALID_LOW, 32'(lo));
		write_register(REG_VALID_HIGH, 32'(hi));
		write_register(REG_MARGIN, margin);
		write_register(REG_TIMEOUT, tmo);
		write_register(REG_SHUT_FAN, shut);
		write_register(REG_GAIN, gain);
		write_register(REG_CYCLE, cyc);
		write_register(REG_MIN_DRIVE, mind);
	endtask

	// Random event mix: mostly plausible ticks with session control in between
	task automatic add_random_events(int n);
		int r, pit;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: gen_now = gen_now + $urandom_range(0, 3000);
					6, 7, 8:          gen_now = gen_now + $urandom_range(0, 2000000);
					default:          gen_now = gen_now + $urandom;
				endcase
				if ($urandom_range(0, 9) == 0)
					pit = int'($signed(16'($urandom)));
				else
					pit = int'($urandom_range(0, 3400)) - 200;
				add_event(FUNC_TICK, gen_now, pit, $urandom_range(0, 29) != 0);
			end else begin
				gen_now = gen_now + $urandom_range(0, 500);
				pit = int'($signed(16'($urandom)));
				if (r < 68)
					add_event(FUNC_START, gen_now, pit, 1'($urandom));
				else if (r < 75)
					add_event(FUNC_STOP, gen_now, pit, 1'($urandom));
				else if (r < 84)
					add_event(FUNC_RAISE, gen_now, pit, 1'($urandom));
				else if (r < 93)
					add_event(FUNC_LOWER, gen_now, pit, 1'($urandom));
				else
					add_event(3'($urandom_range(5, 7)), gen_now, pit, 1'($urandom));
			end
		end
	endtask

	initial begin
		logic [31:0] t;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		taken = 1'b0;
		calm = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		fail_count = 0;
		status_count = 0;
		tick_count = 0;
		cfg_count = 0;
		p_valid_low = -200;
		p_valid_high = 4000;
		p_margin = 100;
		p_timeout = 1800000;
		p_shut_fan = 600000;
		p_gain = 512;
		p_cycle = 20000;
		p_min_drive = 50;
		p_mode = MODE_IDLE;
		p_mode_since = '0;
		p_target = InitialTarget;
		p_drive = 0;
		{p_auger, p_fan, p_igniter} = 3'b000;
		p_cause = CAUSE_NONE;
		gen_now = $urandom;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed walk through every mode with reset settings
		t = 32'd1000;
		add_event(3'(FUNC_LOWER + 1), t, 0, 1'b1);
		add_event(3'(FUNC_LOWER + 2), t, -1, 1'b0);
		add_event(3'(FUNC_LOWER + 3), t, 0, 1'b1);
		add_event(FUNC_TICK, t, 250, 1'b1);
		add_event(FUNC_STOP, t, 0, 1'b1);
		add_event(FUNC_START, t, 0, 1'b1);
		add_event(FUNC_TICK, t + 10, 200, 1'b1);
		add_event(FUNC_TICK, t + 20, 200, 1'b0);         // invalid flag forces error
		add_event(FUNC_TICK, t + 1900000, 32767, 1'b1);  // error kept, first cause kept
		add_event(FUNC_START, t + 1900010, 0, 1'b1);     // ignored in error
		add_event(FUNC_STOP, t + 2000000, 0, 1'b1);
		add_event(FUNC_TICK, t + 2599999, 300, 1'b1);    // fan still on
		add_event(FUNC_TICK, t + 2600000, 300, 1'b1);    // fan time reached, back to idle
		add_event(FUNC_START, 32'hFFFF_0000, 0, 1'b1);
		add_event(FUNC_TICK, 32'hFFFF_0000 + 1800000, 300, 1'b1);  // wraps, not yet late
		add_event(FUNC_TICK, 32'hFFFF_0000 + 1800001, 300, 1'b1);  // startup timeout
		add_event(FUNC_STOP, 32'd5000000, 0, 1'b1);
		add_event(FUNC_START, 32'd5000100, 0, 1'b1);
		add_event(FUNC_TICK, 32'd5000200, 1000, 1'b1);   // near target, to running
		add_event(FUNC_TICK, 32'd5000300, 1200, 1'b1);   // above target, drive 0
		add_event(FUNC_TICK, 32'd5000400, -200, 1'b1);   // drive clamped
		add_event(FUNC_TICK, 32'd5019999, 1099, 1'b1);   // least running drive
		add_event(FUNC_RAISE, 32'd5020000, 0, 1'b1);
		add_event(FUNC_LOWER, 32'd5020001, 0, 1'b1);
		add_event(FUNC_TICK, 32'd5020002, -2000, 1'b1);  // below window
		add_random_events(110);
		drain;

		// Widest window, zero times, unit cycle
		load_settings(-2000, 20000, 0, 0, 0, 0, 1, 0);
		add_random_events(100);
		drain;

		// Extremes: all-ones times, gain and cycle
		load_settings(-2000, 20000, 2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 65535, 1048575, 1000);
		for (int i = 0; i < 46; i++)
			add_event(FUNC_RAISE, gen_now, 0, 1'b1);
		add_random_events(80);
		drain;

		// Empty window: every tick fails
		load_settings(3000, 2999, 50, 4000, 3000, 300, 0, 100);
		for (int i = 0; i < 46; i++)
			add_event(FUNC_LOWER, gen_now, 0, 1'b1);
		add_random_events(60);
		drain;

		// Short times so that timeouts and shutdown ends come often
		load_settings(-200, 3000, 80, 5000, 3000, 300, 1000, 100);
		add_random_events(70);
		drain;

		// Final stretch without idling on either side
		calm = 1'b1;
		load_settings(-200, 4000, 100, 1800000, 600000, 512, 20000, 50);
		add_random_events(90);
		drain;

		$display("Checked %0d status words (%0d ticks) over %0d register writes.",
		         status_count, tick_count, cfg_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
